// ===== src/path_progress_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// Path progress tracker assertion macros
// Property shorthands shared by the tracker modules; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PATH_PROGRESS_TRACKER_ASSERT_SVH
`define PATH_PROGRESS_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define PPT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define PPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PPT_ASSERT_SAME(lbl, ante, cons, msg)
`define PPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/ppt_pkg.sv =====
// ----------------------------------------------------------------------------
// ppt_pkg
// Types, codes and helpers shared by the path progress tracker modules.
// ----------------------------------------------------------------------------
package ppt_pkg;

	localparam int COORD_W = 20;
	localparam int OPND_W  = 22;
	localparam int ACC_W   = 46;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [OPND_W-1:0]  opnd_t;
	typedef opnd_t [2:0]               opnd3_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	// request opcodes
	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_PROJECT = 2'd1;
	localparam logic [1:0] OP_AHEAD   = 2'd2;
	localparam logic [1:0] OP_NEAREST = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [1:0] REG_REACQUIRE   = 2'd1;
	localparam logic [1:0] REG_SEARCH_LIM  = 2'd2;

	function automatic opnd_t sdiff(coord_t a, coord_t b);
		return OPND_W'(a) - OPND_W'(b);
	endfunction

	// component-wise difference a - b
	function automatic opnd3_t diff3(point_t a, point_t b);
		opnd3_t r;
		r[0] = sdiff(a.x, b.x);
		r[1] = sdiff(a.y, b.y);
		r[2] = sdiff(a.z, b.z);
		return r;
	endfunction

	// single operand, other lanes zero
	function automatic opnd3_t scal3(opnd_t v);
		opnd3_t r;
		r[0] = v;
		r[1] = '0;
		r[2] = '0;
		return r;
	endfunction

endpackage

// ===== src/ppt_table.sv =====
// ----------------------------------------------------------------------------
// ppt_table
// Point storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ppt_table import ppt_pkg::*; #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  point_t        wdata,
	input  logic [AW-1:0] raddr,
	output point_t        rdata
);

	point_t mem [DEPTH];
	point_t rd_q;

	// write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

// ===== src/ppt_dot.sv =====
// ----------------------------------------------------------------------------
// ppt_dot
// Shared dot-product unit: one multiplier used over three steps.
// ----------------------------------------------------------------------------
`include "path_progress_tracker_assert.svh"

module ppt_dot import ppt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   go,
	input  opnd3_t op_a,
	input  opnd3_t op_b,
	output logic   done,
	output acc_t   acc
);

	logic [1:0]                     step_q;
	logic                           run_q;
	logic                           done_q;
	logic signed [2*OPND_W-1:0]     prod_q;
	acc_t                           acc_q;

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				step_q <= '0;
				run_q  <= 1'b1;
			end else if (run_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// multiply one lane, accumulate the previous product
	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
		end else if (run_q) begin
			if (step_q != 2'd3) begin
				prod_q <= op_a[step_q] * op_b[step_q];
			end
			if (step_q != 2'd0) begin
				acc_q <= acc_q + ACC_W'(prod_q);
			end
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

	`PPT_ASSERT_NEXT(a_go_runs, go, run_q, "dot unit did not start")
	`PPT_ASSERT_SAME(a_done_idle, done_q, !run_q, "dot unit done while running")
	`PPT_ASSERT_SAME(a_go_quiet, go, !run_q, "dot unit restarted while running")

endmodule

// ===== src/path_progress_tracker.sv =====
// ----------------------------------------------------------------------------
// path_progress_tracker
// Path point table with progress projection, lookahead and nearest search.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears with done for one cycle and must be captured then, since the
// block cannot be held off. A load returns its result the next cycle and
// leaves busy low. Every other request raises busy and walks the point
// table through one shared multiplier (three products per distance or dot
// product) and a one-port table read: a nearest search or lookahead visits
// the stored points one at a time, and a projection advances over the
// segments one at a time, between a setup step and the readout.
`include "path_progress_tracker_assert.svh"

module path_progress_tracker import ppt_pkg::*; #(
	parameter int MAX_POINTS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [1:0]   op,
	input  logic [9:0]   point_index,
	input  coord_t       pos_x,
	input  coord_t       pos_y,
	input  coord_t       pos_z,
	input  logic [19:0]  horizon_mm,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [20:0]  cfg_wdata,
	output logic         done,
	output logic [9:0]   result_index,
	output coord_t       point_x,
	output coord_t       point_y,
	output coord_t       point_z,
	output logic         none_beyond_horizon
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = IW + 1;

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_RDW      = 5'd1;
	localparam logic [4:0] S_PJ_PREV  = 5'd2;
	localparam logic [4:0] S_SEG_GO   = 5'd3;
	localparam logic [4:0] S_DOT_W    = 5'd4;
	localparam logic [4:0] S_LEN_W    = 5'd5;
	localparam logic [4:0] S_CHK_GO   = 5'd6;
	localparam logic [4:0] S_DST_W    = 5'd7;
	localparam logic [4:0] S_R2_W     = 5'd8;
	localparam logic [4:0] S_NS_LIM_W = 5'd9;
	localparam logic [4:0] S_NS_GO    = 5'd10;
	localparam logic [4:0] S_NS_W     = 5'd11;
	localparam logic [4:0] S_LA_H_W   = 5'd12;
	localparam logic [4:0] S_LA_C     = 5'd13;
	localparam logic [4:0] S_LA_GO    = 5'd14;
	localparam logic [4:0] S_LA_W     = 5'd15;
	localparam logic [4:0] S_FIN_OUT  = 5'd16;

	// configuration
	logic [10:0] point_count_q;
	logic [19:0] reacq_q;
	logic [20:0] limit_q;

	// sequencer
	logic [4:0]    state_q;
	logic [4:0]    ret_q;
	logic [1:0]    op_q;
	point_t        q_q;
	point_t        p_q;
	point_t        c_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] e_q;
	logic [IW-1:0] best_q;
	logic          hit_q;
	acc_t          bd_q;
	acc_t          dot_q;
	logic [IW-1:0] raddr_q;
	logic [IW-1:0] res_idx_q;
	logic          flag_q;
	logic [IW-1:0] progress_q;
	logic [IW-1:0] nearest_q;
	logic          go_q;
	opnd3_t        opa_q;
	opnd3_t        opb_q;

	// result registers
	logic          done_q;
	logic [9:0]    result_index_q;
	point_t        out_q;
	logic          flag_out_q;

	logic          accept;
	logic [CW-1:0] n_w;
	logic [CW-1:0] base_w;
	logic          tab_we;
	point_t        rd_w;
	point_t        in_pt;
	logic          dot_done;
	acc_t          dot_acc;
	logic          closer_w;
	logic [IW-1:0] best_nx;
	logic          hit_nx;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] cnt_inc;
	logic [CW-1:0] e_inc;
	logic [CW-1:0] e_wrap;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign in_pt  = '{x: pos_x, y: pos_y, z: pos_z};

	// clamp the point count to the usable range
	always_comb begin
		if (point_count_q < 11'd2) begin
			n_w = CW'(2);
		end else if (32'(point_count_q) > 32'(MAX_POINTS)) begin
			n_w = CW'(MAX_POINTS);
		end else begin
			n_w = CW'(point_count_q);
		end
	end

	// stale progress index restarts at 1
	assign base_w = (CW'(progress_q) >= n_w) ? CW'(1) : CW'(progress_q);

	assign tab_we = accept && (op == OP_LOAD) && (32'(point_index) < 32'(MAX_POINTS));

	assign idx_inc  = idx_q + CW'(1);
	assign cnt_inc  = cnt_q + CW'(1);
	assign e_inc    = e_q + CW'(1);
	assign e_wrap   = (e_inc == n_q) ? '0 : e_inc;
	assign closer_w = (dot_acc < bd_q);
	assign hit_nx   = hit_q || closer_w;
	assign best_nx  = closer_w ? cnt_q[IW-1:0] : best_q;

	ppt_table #(
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (IW'(point_index)),
		.wdata (in_pt),
		.raddr (raddr_q),
		.rdata (rd_w)
	);

	ppt_dot u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q),
		.op_a   (opa_q),
		.op_b   (opb_q),
		.done   (dot_done),
		.acc    (dot_acc)
	);

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= 11'd2;
			reacq_q       <= 20'd1000;
			limit_q       <= 21'd1000000;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_POINT_COUNT: point_count_q <= cfg_wdata[10:0];
				REG_REACQUIRE:   reacq_q       <= cfg_wdata[19:0];
				REG_SEARCH_LIM:  limit_q       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			progress_q <= IW'(1);
			nearest_q  <= '0;
			go_q       <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op)
							OP_LOAD: done_q <= 1'b1;
							OP_PROJECT: begin
								ret_q   <= S_PJ_PREV;
								state_q <= S_RDW;
							end
							OP_AHEAD: begin
								go_q    <= 1'b1;
								state_q <= S_LA_H_W;
							end
							OP_NEAREST: begin
								go_q    <= 1'b1;
								state_q <= S_NS_LIM_W;
							end
							default: ;
						endcase
					end
				end
				S_RDW: state_q <= ret_q;
				S_PJ_PREV: begin
					ret_q   <= S_SEG_GO;
					state_q <= S_RDW;
				end
				S_SEG_GO: begin
					go_q    <= 1'b1;
					state_q <= S_DOT_W;
				end
				S_DOT_W: begin
					if (dot_done) begin
						go_q    <= 1'b1;
						state_q <= S_LEN_W;
					end
				end
				S_LEN_W: begin
					if (dot_done) begin
						if (dot_q > dot_acc && idx_inc < n_q) begin
							ret_q <= S_SEG_GO;
						end else begin
							ret_q <= S_CHK_GO;
						end
						state_q <= S_RDW;
					end
				end
				S_CHK_GO: begin
					go_q    <= 1'b1;
					state_q <= S_DST_W;
				end
				S_DST_W: begin
					if (dot_done) begin
						go_q    <= 1'b1;
						state_q <= S_R2_W;
					end
				end
				S_R2_W: begin
					if (dot_done) begin
						if (dot_q > dot_acc) begin
							go_q    <= 1'b1;
							state_q <= S_NS_LIM_W;
						end else begin
							progress_q <= idx_q[IW-1:0];
							ret_q      <= S_FIN_OUT;
							state_q    <= S_RDW;
						end
					end
				end
				S_NS_LIM_W: begin
					if (dot_done) begin
						ret_q   <= S_NS_GO;
						state_q <= S_RDW;
					end
				end
				S_NS_GO: begin
					go_q    <= 1'b1;
					state_q <= S_NS_W;
				end
				S_NS_W: begin
					if (dot_done) begin
						if (cnt_inc < n_q) begin
							ret_q <= S_NS_GO;
						end else begin
							ret_q <= S_FIN_OUT;
							if (op_q == OP_PROJECT) begin
								progress_q <= hit_nx ? best_nx : idx_q[IW-1:0];
							end
							if (hit_nx) begin
								nearest_q <= best_nx;
							end
						end
						state_q <= S_RDW;
					end
				end
				S_LA_H_W: begin
					if (dot_done) begin
						ret_q   <= S_LA_C;
						state_q <= S_RDW;
					end
				end
				S_LA_C: begin
					ret_q   <= S_LA_GO;
					state_q <= S_RDW;
				end
				S_LA_GO: begin
					go_q    <= 1'b1;
					state_q <= S_LA_W;
				end
				S_LA_W: begin
					if (dot_done) begin
						if (dot_acc < bd_q && cnt_inc < n_q) begin
							ret_q <= S_LA_GO;
						end else begin
							ret_q <= S_FIN_OUT;
						end
						state_q <= S_RDW;
					end
				end
				S_FIN_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				op_q  <= op;
				q_q   <= in_pt;
				n_q   <= n_w;
				idx_q <= base_w;
				if (accept) begin
					unique case (op)
						OP_LOAD: begin
							result_index_q <= point_index;
							out_q          <= in_pt;
							flag_out_q     <= 1'b0;
						end
						// the segment into point 0 starts at the last point in use
						OP_PROJECT: raddr_q <= (base_w == '0) ? IW'(n_w - CW'(1))
							: IW'(base_w - CW'(1));
						OP_AHEAD: begin
							opa_q <= scal3(OPND_W'(horizon_mm));
							opb_q <= scal3(OPND_W'(horizon_mm));
						end
						OP_NEAREST: begin
							opa_q <= scal3(OPND_W'(limit_q));
							opb_q <= scal3(OPND_W'(limit_q));
						end
						default: ;
					endcase
				end
			end
			S_PJ_PREV: begin
				p_q     <= rd_w;
				raddr_q <= idx_q[IW-1:0];
			end
			S_SEG_GO: begin
				c_q   <= rd_w;
				opa_q <= diff3(q_q, p_q);
				opb_q <= diff3(rd_w, p_q);
			end
			S_DOT_W: begin
				if (dot_done) begin
					dot_q <= dot_acc;
					opa_q <= opb_q;
				end
			end
			S_LEN_W: begin
				// advance past the segment, or wrap at the end
				if (dot_done) begin
					if (dot_q > dot_acc) begin
						if (idx_inc < n_q) begin
							idx_q   <= idx_inc;
							p_q     <= c_q;
							raddr_q <= idx_inc[IW-1:0];
						end else begin
							idx_q   <= CW'(1);
							raddr_q <= IW'(1);
						end
					end else begin
						raddr_q <= idx_q[IW-1:0];
					end
				end
			end
			S_CHK_GO: begin
				opa_q <= diff3(rd_w, q_q);
				opb_q <= diff3(rd_w, q_q);
			end
			S_DST_W: begin
				if (dot_done) begin
					dot_q <= dot_acc;
					opa_q <= scal3(OPND_W'(reacq_q));
					opb_q <= scal3(OPND_W'(reacq_q));
				end
			end
			S_R2_W: begin
				if (dot_done) begin
					opa_q     <= scal3(OPND_W'(limit_q));
					opb_q     <= scal3(OPND_W'(limit_q));
					raddr_q   <= idx_q[IW-1:0];
					res_idx_q <= idx_q[IW-1:0];
					flag_q    <= 1'b0;
				end
			end
			S_NS_LIM_W: begin
				if (dot_done) begin
					bd_q    <= dot_acc;
					cnt_q   <= '0;
					hit_q   <= 1'b0;
					raddr_q <= '0;
				end
			end
			S_NS_GO: begin
				opa_q <= diff3(rd_w, q_q);
				opb_q <= diff3(rd_w, q_q);
			end
			S_NS_W: begin
				// keep the strictly closer point
				if (dot_done) begin
					if (closer_w) begin
						bd_q <= dot_acc;
					end
					best_q <= best_nx;
					hit_q  <= hit_nx;
					if (cnt_inc < n_q) begin
						cnt_q   <= cnt_inc;
						raddr_q <= cnt_inc[IW-1:0];
					end else begin
						flag_q <= 1'b0;
						if (op_q == OP_PROJECT) begin
							res_idx_q <= hit_nx ? best_nx : idx_q[IW-1:0];
							raddr_q   <= hit_nx ? best_nx : idx_q[IW-1:0];
						end else begin
							res_idx_q <= hit_nx ? best_nx : nearest_q;
							raddr_q   <= hit_nx ? best_nx : nearest_q;
						end
					end
				end
			end
			S_LA_H_W: begin
				if (dot_done) begin
					bd_q    <= dot_acc;
					raddr_q <= idx_q[IW-1:0];
				end
			end
			S_LA_C: begin
				c_q     <= rd_w;
				cnt_q   <= CW'(1);
				e_q     <= (idx_inc == n_q) ? '0 : idx_inc;
				raddr_q <= (idx_inc == n_q) ? '0 : idx_inc[IW-1:0];
			end
			S_LA_GO: begin
				opa_q <= diff3(rd_w, c_q);
				opb_q <= diff3(rd_w, c_q);
			end
			S_LA_W: begin
				// first point at or beyond the horizon wins
				if (dot_done) begin
					if (dot_acc >= bd_q) begin
						res_idx_q <= e_q[IW-1:0];
						raddr_q   <= e_q[IW-1:0];
						flag_q    <= 1'b0;
					end else if (cnt_inc < n_q) begin
						cnt_q   <= cnt_inc;
						e_q     <= e_wrap;
						raddr_q <= e_wrap[IW-1:0];
					end else begin
						res_idx_q <= idx_q[IW-1:0];
						raddr_q   <= idx_q[IW-1:0];
						flag_q    <= 1'b1;
					end
				end
			end
			S_FIN_OUT: begin
				result_index_q <= 10'(res_idx_q);
				out_q          <= rd_w;
				flag_out_q     <= flag_q;
			end
			default: ;
		endcase
	end

	assign done                = done_q;
	assign result_index        = result_index_q;
	assign point_x             = out_q.x;
	assign point_y             = out_q.y;
	assign point_z             = out_q.z;
	assign none_beyond_horizon = flag_out_q;

	`PPT_ASSERT_SAME(a_done_not_busy, done_q, !busy, "result strobed while busy")
	`PPT_ASSERT_NEXT(a_load_one_cycle, accept && op == OP_LOAD, done_q, "load result missing")
	`PPT_ASSERT_NEXT(a_walk_busy, accept && op != OP_LOAD, busy, "walk request did not raise busy")

endmodule

// ===== bench/path_progress_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_progress_tracker_tb
// Drives loads, projections, lookaheads and nearest searches into the
// tracker under several register settings and sender gap rates, predicts
// every result from a behavioral copy of the table and progress state, and
// checks each done strobe against the oldest predicted result.
// ----------------------------------------------------------------------------

import ppt_pkg::*;

typedef struct {
	logic [9:0] idx;
	coord_t     x;
	coord_t     y;
	coord_t     z;
	logic       flag;
} track_res_t;

class track_scoreboard;
	localparam int DEPTH = 1024;
	longint tx[DEPTH];
	longint ty[DEPTH];
	longint tz[DEPTH];
	bit loaded[DEPTH];
	int unsigned prog_idx;
	int unsigned near_idx;
	int unsigned pt_count;
	longint reacq;
	longint lim;
	track_res_t pending[$];
	int errors;

	function void clear();
		foreach (loaded[i]) loaded[i] = 0;
		prog_idx = 1;
		near_idx = 0;
		pt_count = 2;
		reacq = 1000;
		lim = 1000000;
		errors = 0;
	endfunction

	function void set_reg(logic [1:0] addr, logic [20:0] val);
		case (addr)
			REG_POINT_COUNT: pt_count = val[10:0];
			REG_REACQUIRE:   reacq = val[19:0];
			REG_SEARCH_LIM:  lim = val;
			default: ;
		endcase
	endfunction

	function int unsigned in_use();
		if (pt_count < 2) return 2;
		if (pt_count > DEPTH) return DEPTH;
		return pt_count;
	endfunction

	function longint d2(int unsigned i, longint x, longint y, longint z);
		longint dx, dy, dz;
		dx = tx[i] - x;
		dy = ty[i] - y;
		dz = tz[i] - z;
		return dx * dx + dy * dy + dz * dz;
	endfunction

	// query lies beyond the far end of the segment ending at idx
	function bit past_end(int unsigned idx, int unsigned n, longint x, longint y, longint z);
		int unsigned p;
		longint sx, sy, sz;
		p = (idx == 0) ? n - 1 : idx - 1;
		sx = tx[idx] - tx[p];
		sy = ty[idx] - ty[p];
		sz = tz[idx] - tz[p];
		return ((x - tx[p]) * sx + (y - ty[p]) * sy + (z - tz[p]) * sz)
			> (sx * sx + sy * sy + sz * sz);
	endfunction

	function bit closest(int unsigned n, longint x, longint y, longint z,
			output int unsigned best);
		longint bd, d;
		bit hit;
		bd = lim * lim;
		hit = 0;
		best = 0;
		for (int unsigned i = 0; i < n; i++) begin
			d = d2(i, x, y, z);
			if (d < bd) begin
				bd = d;
				best = i;
				hit = 1;
			end
		end
		return hit;
	endfunction

	function void push(int unsigned i, logic flag);
		track_res_t r;
		r.idx = 10'(i);
		r.x = coord_t'(tx[i]);
		r.y = coord_t'(ty[i]);
		r.z = coord_t'(tz[i]);
		r.flag = flag;
		pending.insert(pending.size(), r);
	endfunction

	// predict the result of one accepted request
	function void note_request(logic [1:0] op, logic [9:0] slot, coord_t px, coord_t py,
			coord_t pz, logic [19:0] hor);
		int unsigned n, base, idx, b;
		longint x, y, z, h2;
		bit found;
		track_res_t r;
		x = px;
		y = py;
		z = pz;
		n = in_use();
		base = (prog_idx >= n) ? 1 : prog_idx;
		case (op)
			OP_LOAD: begin
				tx[slot] = x;
				ty[slot] = y;
				tz[slot] = z;
				loaded[slot] = 1;
				r.idx = slot;
				r.x = px;
				r.y = py;
				r.z = pz;
				r.flag = 0;
				pending.insert(pending.size(), r);
			end
			OP_PROJECT: begin
				idx = base;
				while (idx < n && past_end(idx, n, x, y, z)) idx++;
				if (idx >= n) idx = 1;
				if (d2(idx, x, y, z) > reacq * reacq) begin
					if (closest(n, x, y, z, b)) begin
						near_idx = b;
						idx = b;
					end
				end
				prog_idx = idx;
				push(idx, 0);
			end
			OP_AHEAD: begin
				h2 = longint'(hor) * longint'(hor);
				found = 0;
				for (int unsigned f = 1; f < n && !found; f++) begin
					idx = (base + f) % n;
					if (d2(idx, tx[base], ty[base], tz[base]) >= h2) begin
						push(idx, 0);
						found = 1;
					end
				end
				if (!found) push(base, 1);
			end
			default: begin
				if (closest(n, x, y, z, b)) near_idx = b;
				push(near_idx, 0);
			end
		endcase
	endfunction

	// compare one strobed result with the oldest prediction
	function void check_result(track_res_t act);
		track_res_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result index %0d", $time, act.idx);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (act.idx !== e.idx) begin
			$display("%0t: result_index exp %0d got %0d", $time, e.idx, act.idx);
			errors++;
		end
		if (act.x !== e.x) begin
			$display("%0t: point_x exp %0d got %0d", $time, e.x, act.x);
			errors++;
		end
		if (act.y !== e.y) begin
			$display("%0t: point_y exp %0d got %0d", $time, e.y, act.y);
			errors++;
		end
		if (act.z !== e.z) begin
			$display("%0t: point_z exp %0d got %0d", $time, e.z, act.z);
			errors++;
		end
		if (act.flag !== e.flag) begin
			$display("%0t: none_beyond_horizon exp %0b got %0b", $time, e.flag, act.flag);
			errors++;
		end
	endfunction
endclass

module path_progress_tracker_tb;
	localparam int CYCLE_LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [9:0]  point_index;
	coord_t      pos_x;
	coord_t      pos_y;
	coord_t      pos_z;
	logic [19:0] horizon_mm;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [20:0] cfg_wdata;
	logic        done;
	logic [9:0]  result_index;
	coord_t      point_x;
	coord_t      point_y;
	coord_t      point_z;
	logic        none_beyond_horizon;

	track_scoreboard sb;
	int idle_pct;
	longint cycles = 0;

	path_progress_tracker dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.point_index(point_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.horizon_mm(horizon_mm), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .done(done), .result_index(result_index),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.none_beyond_horizon(none_beyond_horizon)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// check each strobed result
	always @(posedge clk) begin
		track_res_t r;
		if (arst_n && done) begin
			r.idx = result_index;
			r.x = point_x;
			r.y = point_y;
			r.z = point_z;
			r.flag = none_beyond_horizon;
			sb.check_result(r);
		end
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("path_progress_tracker_tb: done, errors");
			$finish;
		end
	end

	function automatic coord_t clamp20(longint v);
		if (v > 524287) return 524287;
		if (v < -524288) return -524288;
		return coord_t'(v);
	endfunction

	// hand one request over, wait for it to be taken, then maybe idle
	task automatic send(logic [1:0] o, logic [9:0] slot, coord_t x, coord_t y, coord_t z,
			logic [19:0] hor);
		@(negedge clk);
		start <= 1'b1;
		op <= o;
		point_index <= slot;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		horizon_mm <= hor;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(o, slot, x, y, z, hor);
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(5)) @(negedge clk);
		end
	endtask

	// drain outstanding results, then write one register while idle
	task automatic write_reg(logic [1:0] addr, logic [20:0] val);
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		sb.set_reg(addr, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// path-shaped point for a slot: a wavy line with noise
	task automatic load_slot(int unsigned s);
		longint bx, by, bz;
		bx = longint'(s) * 300 + longint'($urandom_range(200)) - 100;
		by = longint'(s % 50) * 400 + longint'($urandom_range(200)) - 100;
		bz = longint'($urandom_range(2000)) - 1000;
		if ($urandom_range(19) == 0) begin
			bx = $signed(20'($urandom));
			by = $signed(20'($urandom));
			bz = $signed(20'($urandom));
		end else if ($urandom_range(19) == 0 && s > 0 && sb.loaded[s - 1]) begin
			bx = sb.tx[s - 1];
			by = sb.ty[s - 1];
			bz = sb.tz[s - 1];
		end
		send(OP_LOAD, 10'(s), clamp20(bx), clamp20(by), clamp20(bz), 20'($urandom));
	endtask

	task automatic random_item();
		int unsigned n, k, miss;
		logic [1:0] o;
		logic [19:0] hor;
		longint spread;
		coord_t qx, qy, qz;
		n = sb.in_use();
		miss = n;
		for (int unsigned i = 0; i < n && miss == n; i++)
			if (!sb.loaded[i]) miss = i;
		if (miss != n) begin
			load_slot(miss);
			return;
		end
		if ($urandom_range(99) < 25) begin
			k = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(n - 1);
			load_slot(k);
			return;
		end
		o = 2'($urandom_range(3, 1));
		k = $urandom_range(n - 1);
		spread = ($urandom_range(3) == 0) ? 5000 : 400;
		if ($urandom_range(9) == 0) begin
			qx = $signed(20'($urandom));
			qy = $signed(20'($urandom));
			qz = $signed(20'($urandom));
		end else begin
			qx = clamp20(sb.tx[k] + longint'($urandom_range(2 * spread)) - spread);
			qy = clamp20(sb.ty[k] + longint'($urandom_range(2 * spread)) - spread);
			qz = clamp20(sb.tz[k] + longint'($urandom_range(2 * spread)) - spread);
		end
		hor = ($urandom_range(4) == 0) ? 20'($urandom) : 20'($urandom_range(3000));
		send(o, 10'($urandom), qx, qy, qz, hor);
	endtask

	task automatic run_phase(logic [10:0] cnt, logic [19:0] ra, logic [20:0] sl, int items,
			int pct);
		write_reg(REG_POINT_COUNT, cnt);
		write_reg(REG_REACQUIRE, ra);
		write_reg(REG_SEARCH_LIM, sl);
		idle_pct = pct;
		repeat (items) random_item();
	endtask

	initial begin
		sb = new();
		sb.clear();
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_LOAD;
		point_index = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		horizon_mm = '0;
		cfg_we = 1'b0;
		cfg_addr = REG_POINT_COUNT;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: a small ring with extremes and a repeated point
		write_reg(REG_POINT_COUNT, 11'd6);
		send(OP_LOAD, 10'd0, 20'sd0, 20'sd0, 20'sd0, 20'd0);
		send(OP_LOAD, 10'd1, 20'sd1000, 20'sd0, 20'sd0, 20'd0);
		send(OP_LOAD, 10'd2, 20'sd1000, 20'sd0, 20'sd0, 20'd0);
		send(OP_LOAD, 10'd3, 20'sd2000, 20'sd1000, -20'sd500, 20'd0);
		send(OP_LOAD, 10'd4, 20'sd524287, 20'sd524287, 20'sd524287, 20'd0);
		send(OP_LOAD, 10'd5, -20'sd524288, -20'sd524288, -20'sd524288, 20'd0);
		send(OP_LOAD, 10'd1023, 20'sd7, -20'sd7, 20'sd7, 20'hFFFFF);
		send(OP_PROJECT, 10'd0, 20'sd1500, 20'sd0, 20'sd0, 20'd0);
		send(OP_PROJECT, 10'd0, 20'sd2100, 20'sd1000, -20'sd500, 20'd0);
		send(OP_PROJECT, 10'd0, 20'sd524287, 20'sd524287, 20'sd524287, 20'd0);
		send(OP_PROJECT, 10'd0, -20'sd524288, -20'sd524288, -20'sd524288, 20'd0);
		send(OP_AHEAD, 10'd0, 20'sd0, 20'sd0, 20'sd0, 20'd0);
		send(OP_AHEAD, 10'd0, 20'sd0, 20'sd0, 20'sd0, 20'hFFFFF);
		send(OP_AHEAD, 10'd0, 20'sd0, 20'sd0, 20'sd0, 20'd1500);
		send(OP_NEAREST, 10'd0, 20'sd10, 20'sd10, 20'sd10, 20'd0);
		send(OP_NEAREST, 10'd0, 20'sd524287, -20'sd524288, 20'sd0, 20'd0);
		// shrink the count below the progress index: stale index
		write_reg(REG_POINT_COUNT, 11'd3);
		send(OP_AHEAD, 10'd0, 20'sd0, 20'sd0, 20'sd0, 20'd10);
		send(OP_PROJECT, 10'd0, 20'sd900, 20'sd0, 20'sd0, 20'd0);
		// nothing within the search limit
		write_reg(REG_SEARCH_LIM, 21'd0);
		write_reg(REG_REACQUIRE, 20'd0);
		send(OP_PROJECT, 10'd0, 20'sd5000, 20'sd5000, 20'sd5000, 20'd0);
		send(OP_NEAREST, 10'd0, 20'sd5000, 20'sd5000, 20'sd5000, 20'd0);

		// random phases across settings and sender gap rates
		run_phase(11'd8, 20'd1000, 21'd1000000, 55, 0);
		run_phase(11'd0, 20'd0, 21'd2097151, 30, 57);
		run_phase(11'd16, 20'd300, 21'd20000, 55, 30);
		run_phase(11'd1, 20'd1048575, 21'd1000, 20, 0);
		run_phase(11'd12, 20'd50, 21'd0, 30, 57);
		run_phase(11'd40, 20'd2000, 21'd1000000, 50, 30);
		// oversized and full counts: the loads keep filling the table
		run_phase(11'd2047, 20'd500, 21'd2097151, 8, 0);
		run_phase(11'd1024, 20'd100, 21'd1000000, 8, 30);
		run_phase(11'd10, 20'd800, 21'd1000000, 15, 0);

		@(negedge clk);
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("path_progress_tracker_tb: done, clean");
		else
			$display("path_progress_tracker_tb: done, errors");
		$finish;
	end
endmodule
